/* rtl/vbp_pkg.sv */
`default_nettype none

package vbp_pkg;

    localparam int unsigned STEP_W      = 16;
    localparam int unsigned PERCENT_W   = 7;
    localparam int unsigned ANGLE_W     = 8;
    localparam int unsigned CFG_ADDR_W  = 1;

    localparam logic [STEP_W-1:0] PERCENT_STEP_RESET = 16'd300;
    localparam logic [STEP_W-1:0] ANGLE_STEP_RESET   = 16'd11;

    localparam logic [PERCENT_W-1:0]      PERCENT_MAX = 7'd100;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX   = 8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN   = -8'sd90;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_OPEN    = 3'd1,
        MODE_CLOSE   = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_PERCENT = 3'd4,
        MODE_ANGLE   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOPPED = 2'd0,
        DIR_OPENING = 2'd1,
        DIR_CLOSING = 2'd2
    } dir_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PERCENT_STEP = 1'b0,
        REG_ANGLE_STEP   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        mode_t                      mode;
        logic [PERCENT_W-1:0]       goal_percent;
        logic signed [ANGLE_W-1:0]  goal_angle;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]                 motion;
        logic                       open_relay;
        logic                       close_relay;
        logic [PERCENT_W-1:0]       position_percent;
        logic signed [ANGLE_W-1:0]  slat_angle;
    } out_beat_t;

    typedef struct packed {
        dir_t                       direction;
        logic [PERCENT_W-1:0]       percent_now;
        logic signed [ANGLE_W-1:0]  angle_now;
        logic [PERCENT_W-1:0]       percent_goal;
        logic                       percent_goal_held;
        logic signed [ANGLE_W-1:0]  angle_goal;
        logic                       angle_goal_held;
        logic [STEP_W-1:0]          percent_prescale;
        logic [STEP_W-1:0]          angle_prescale;
        logic                       angle_running;
    } blind_state_t;

    // start or stop: drop goals, restart both prescalers
    function automatic blind_state_t set_motion(blind_state_t s, dir_t dir);
        blind_state_t r;
        r                   = s;
        r.percent_goal_held = 1'b0;
        r.angle_goal_held   = 1'b0;
        r.direction         = dir;
        r.percent_prescale  = '0;
        r.angle_prescale    = '0;
        r.angle_running     = (dir != DIR_STOPPED);
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/venetian_blind_positioner.sv */
`default_nettype none

// Time-based position estimator for a relay-driven venetian blind. Every input
// beat (a base-time tick or an open/close/stop/go-to-percent/go-to-angle
// command) produces exactly one result beat carrying motion, both relay
// drives, the closed percentage and the slat angle. Beats pass through an
// input register and a result register with one short update step between
// them, so one beat is taken every clock unless the result consumer stalls;
// the only limit on rate is that consumer. The user must write the two step
// registers (base ticks per percent and per degree, zero treated as one)
// through the cfg port while no beat is in flight; the block does not check.
module venetian_blind_positioner (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire vbp_pkg::in_beat_t                   s_data,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output vbp_pkg::out_beat_t                       m_data,

    input  wire logic                                cfg_wr_en,
    input  wire logic [vbp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [vbp_pkg::STEP_W-1:0]          cfg_wr_data
);

    // step registers
    logic [vbp_pkg::STEP_W-1:0] percent_step_reg;
    logic [vbp_pkg::STEP_W-1:0] angle_step_reg;

    // input register stage
    logic               in_valid_reg;
    vbp_pkg::in_beat_t  in_data_reg;

    // result register stage
    logic               out_valid_reg;
    vbp_pkg::out_beat_t out_data_reg;

    // blind state
    vbp_pkg::blind_state_t st_reg;
    vbp_pkg::blind_state_t st_next;
    vbp_pkg::out_beat_t    result_next;

    logic advance;

    // input beat moves on whenever the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            percent_step_reg <= vbp_pkg::PERCENT_STEP_RESET;
            angle_step_reg   <= vbp_pkg::ANGLE_STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                vbp_pkg::REG_PERCENT_STEP: percent_step_reg <= cfg_wr_data;
                vbp_pkg::REG_ANGLE_STEP:   angle_step_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // state update for the beat in the input register
    always_comb begin
        logic [vbp_pkg::STEP_W-1:0]         pstep;
        logic [vbp_pkg::STEP_W-1:0]         astep;
        logic [vbp_pkg::STEP_W-1:0]         pinc;
        logic [vbp_pkg::STEP_W-1:0]         ainc;
        logic [vbp_pkg::PERCENT_W-1:0]      gp;
        logic signed [vbp_pkg::ANGLE_W-1:0] ga;

        pinc  = '0;
        ainc  = '0;
        pstep = (percent_step_reg == '0) ? vbp_pkg::STEP_W'(1) : percent_step_reg;
        astep = (angle_step_reg == '0) ? vbp_pkg::STEP_W'(1) : angle_step_reg;
        gp    = (in_data_reg.goal_percent > vbp_pkg::PERCENT_MAX) ?
                vbp_pkg::PERCENT_MAX : in_data_reg.goal_percent;
        ga    = in_data_reg.goal_angle;
        if (ga > vbp_pkg::ANGLE_MAX) begin
            ga = vbp_pkg::ANGLE_MAX;
        end
        if (ga < vbp_pkg::ANGLE_MIN) begin
            ga = vbp_pkg::ANGLE_MIN;
        end

        st_next = st_reg;

        case (in_data_reg.mode)
            vbp_pkg::MODE_TICK: begin
                if (st_next.direction != vbp_pkg::DIR_STOPPED) begin
                    // percent prescaler and step
                    pinc = st_next.percent_prescale + vbp_pkg::STEP_W'(1);
                    if (pinc < pstep) begin
                        st_next.percent_prescale = pinc;
                    end else begin
                        st_next.percent_prescale = '0;
                        if (st_next.direction == vbp_pkg::DIR_CLOSING) begin
                            if (st_next.percent_now >= vbp_pkg::PERCENT_MAX) begin
                                st_next.percent_now = vbp_pkg::PERCENT_MAX;
                                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_STOPPED);
                            end else begin
                                st_next.percent_now = st_next.percent_now + 7'd1;
                            end
                        end else if (st_next.direction == vbp_pkg::DIR_OPENING) begin
                            if (st_next.percent_now == '0) begin
                                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_STOPPED);
                            end else begin
                                st_next.percent_now = st_next.percent_now - 7'd1;
                            end
                        end
                        if (st_next.percent_goal_held &&
                            st_next.percent_goal == st_next.percent_now) begin
                            st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_STOPPED);
                        end
                    end

                    // angle stage only if the percent stage left the blind moving
                    if (st_next.direction != vbp_pkg::DIR_STOPPED &&
                        st_next.angle_running) begin
                        ainc = st_next.angle_prescale + vbp_pkg::STEP_W'(1);
                        if (ainc < astep) begin
                            st_next.angle_prescale = ainc;
                        end else begin
                            st_next.angle_prescale = '0;
                            if (st_next.direction == vbp_pkg::DIR_CLOSING) begin
                                if (st_next.angle_now < vbp_pkg::ANGLE_MAX) begin
                                    st_next.angle_now = st_next.angle_now + 8'sd1;
                                end else begin
                                    st_next.angle_now     = vbp_pkg::ANGLE_MAX;
                                    st_next.angle_running = 1'b0;
                                end
                            end else if (st_next.direction == vbp_pkg::DIR_OPENING) begin
                                if (st_next.angle_now > vbp_pkg::ANGLE_MIN) begin
                                    st_next.angle_now = st_next.angle_now - 8'sd1;
                                end else begin
                                    st_next.angle_now     = vbp_pkg::ANGLE_MIN;
                                    st_next.angle_running = 1'b0;
                                end
                            end
                            if (st_next.angle_goal_held &&
                                st_next.angle_goal == st_next.angle_now) begin
                                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_STOPPED);
                            end
                        end
                    end
                end
            end
            vbp_pkg::MODE_OPEN: begin
                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_OPENING);
            end
            vbp_pkg::MODE_CLOSE: begin
                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_CLOSING);
            end
            vbp_pkg::MODE_STOP: begin
                st_next = vbp_pkg::set_motion(st_next, vbp_pkg::DIR_STOPPED);
            end
            vbp_pkg::MODE_PERCENT: begin
                // a goal already met leaves any motion alone
                if (gp != st_next.percent_now) begin
                    st_next = vbp_pkg::set_motion(st_next, (gp > st_next.percent_now) ?
                              vbp_pkg::DIR_CLOSING : vbp_pkg::DIR_OPENING);
                    st_next.percent_goal      = gp;
                    st_next.percent_goal_held = 1'b1;
                end
            end
            vbp_pkg::MODE_ANGLE: begin
                if (ga != st_next.angle_now) begin
                    st_next = vbp_pkg::set_motion(st_next, (ga > st_next.angle_now) ?
                              vbp_pkg::DIR_CLOSING : vbp_pkg::DIR_OPENING);
                    st_next.angle_goal      = ga;
                    st_next.angle_goal_held = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result beat from the updated state
    always_comb begin
        result_next.motion           = st_next.direction;
        result_next.open_relay       = (st_next.direction == vbp_pkg::DIR_OPENING);
        result_next.close_relay      = (st_next.direction == vbp_pkg::DIR_CLOSING);
        result_next.position_percent = st_next.percent_now;
        result_next.slat_angle       = st_next.angle_now;
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
module tb;
    import vbp_pkg::*;

    // run shape
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_BEATS    = 210;
    localparam int HOLD_CYCLES    = 90;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 100;

    // mode codes the block must ignore
    localparam mode_t MODE_UNDEF_6 = mode_t'(3'd6);
    localparam mode_t MODE_UNDEF_7 = mode_t'(3'd7);

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [STEP_W-1:0]     cfg_wr_data;

    venetian_blind_positioner DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // free-running clock, period 2
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // blind position estimate: our own copy of the block's state
    // ------------------------------------------------------------------
    dir_t                     est_dir;
    logic [PERCENT_W-1:0]     est_pct;
    logic signed [ANGLE_W-1:0] est_ang;
    logic [PERCENT_W-1:0]     est_pct_goal;
    logic signed [ANGLE_W-1:0] est_ang_goal;
    bit                       est_pct_goal_on;
    bit                       est_ang_goal_on;
    logic [STEP_W-1:0]        est_pct_pre;
    logic [STEP_W-1:0]        est_ang_pre;
    bit                       est_ang_run;
    logic [STEP_W-1:0]        ticks_per_percent;
    logic [STEP_W-1:0]        ticks_per_degree;

    // position estimates still owed by the block, oldest first
    out_beat_t                pending_positions[$];

    int                       error_count;
    int                       result_index;
    int                       stall_cycles;
    bit                       idle_on;
    bit                       hold_req;

    function automatic void est_reset();
        ticks_per_percent = PERCENT_STEP_RESET;
        ticks_per_degree  = ANGLE_STEP_RESET;
        est_dir           = DIR_STOPPED;
        est_pct           = '0;
        est_ang           = '0;
        est_pct_goal      = '0;
        est_ang_goal      = '0;
        est_pct_goal_on   = 1'b0;
        est_ang_goal_on   = 1'b0;
        est_pct_pre       = '0;
        est_ang_pre       = '0;
        est_ang_run       = 1'b0;
    endfunction

    // any start or stop drops both goals and restarts the prescalers
    function automatic void est_drive(dir_t d);
        est_pct_goal_on = 1'b0;
        est_ang_goal_on = 1'b0;
        est_dir         = d;
        est_pct_pre     = '0;
        est_ang_pre     = '0;
        est_ang_run     = (d != DIR_STOPPED);
    endfunction

    // percent prescaler, then step toward the travel limit
    function automatic void percent_tick();
        logic [STEP_W-1:0] step;
        step        = (ticks_per_percent == '0) ? 16'd1 : ticks_per_percent;
        est_pct_pre = est_pct_pre + 16'd1;
        if (est_pct_pre < step) return;
        est_pct_pre = '0;
        if (est_dir == DIR_CLOSING) begin
            if (est_pct >= PERCENT_MAX) begin
                est_pct = PERCENT_MAX;
                est_drive(DIR_STOPPED);
            end else begin
                est_pct = est_pct + 7'd1;
            end
        end else if (est_dir == DIR_OPENING) begin
            if (est_pct == '0) begin
                est_drive(DIR_STOPPED);
            end else begin
                est_pct = est_pct - 7'd1;
            end
        end
        if (est_pct_goal_on && est_pct_goal == est_pct) est_drive(DIR_STOPPED);
    endfunction

    // slat prescaler; at the slat limit only the slat stops turning
    function automatic void angle_tick();
        logic [STEP_W-1:0] step;
        step        = (ticks_per_degree == '0) ? 16'd1 : ticks_per_degree;
        est_ang_pre = est_ang_pre + 16'd1;
        if (est_ang_pre < step) return;
        est_ang_pre = '0;
        if (est_dir == DIR_CLOSING) begin
            if (est_ang < ANGLE_MAX) begin
                est_ang = est_ang + 8'sd1;
            end else begin
                est_ang     = ANGLE_MAX;
                est_ang_run = 1'b0;
            end
        end else if (est_dir == DIR_OPENING) begin
            if (est_ang > ANGLE_MIN) begin
                est_ang = est_ang - 8'sd1;
            end else begin
                est_ang     = ANGLE_MIN;
                est_ang_run = 1'b0;
            end
        end
        if (est_ang_goal_on && est_ang_goal == est_ang) est_drive(DIR_STOPPED);
    endfunction

    // advance the estimate by one input beat and return the report
    function automatic out_beat_t blind_estimate(in_beat_t b);
        logic [PERCENT_W-1:0]      gp;
        logic signed [ANGLE_W-1:0] ga;
        out_beat_t                 r;
        case (b.mode)
            MODE_TICK: begin
                // percent stage first, a stop there skips the slat
                if (est_dir != DIR_STOPPED) begin
                    percent_tick();
                    if (est_dir != DIR_STOPPED && est_ang_run) angle_tick();
                end
            end
            MODE_OPEN:  est_drive(DIR_OPENING);
            MODE_CLOSE: est_drive(DIR_CLOSING);
            MODE_STOP:  est_drive(DIR_STOPPED);
            MODE_PERCENT: begin
                gp = (b.goal_percent > PERCENT_MAX) ? PERCENT_MAX : b.goal_percent;
                // a goal already met leaves any motion running
                if (gp != est_pct) begin
                    est_drive(gp > est_pct ? DIR_CLOSING : DIR_OPENING);
                    est_pct_goal    = gp;
                    est_pct_goal_on = 1'b1;
                end
            end
            MODE_ANGLE: begin
                ga = b.goal_angle;
                if (ga > ANGLE_MAX) ga = ANGLE_MAX;
                if (ga < ANGLE_MIN) ga = ANGLE_MIN;
                if (ga != est_ang) begin
                    est_drive(ga > est_ang ? DIR_CLOSING : DIR_OPENING);
                    est_ang_goal    = ga;
                    est_ang_goal_on = 1'b1;
                end
            end
            default: ;  // undefined modes leave the state alone
        endcase
        r.motion           = est_dir;
        r.open_relay       = (est_dir == DIR_OPENING);
        r.close_relay      = (est_dir == DIR_CLOSING);
        r.position_percent = est_pct;
        r.slat_angle       = est_ang;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (error_count < PRINT_CAP) $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      result_index, name, got, want));
    endtask

    // every result beat is matched against the oldest estimate owed
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_positions.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          result_index));
            end else begin
                want = pending_positions.pop_front();
                check_field("motion", int'(m_data.motion), int'(want.motion));
                check_field("open_relay", int'(m_data.open_relay),
                            int'(want.open_relay));
                check_field("close_relay", int'(m_data.close_relay),
                            int'(want.close_relay));
                check_field("position_percent", int'(m_data.position_percent),
                            int'(want.position_percent));
                check_field("slat_angle", int'(m_data.slat_angle),
                            int'(want.slat_angle));
            end
            result_index++;
        end
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // long hold so the block fills up and drops s_ready
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offer one beat, hold it until taken, then record what it should give
    task automatic send_beat(in_beat_t b, bit typed, out_beat_t typed_want);
        out_beat_t predicted;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = blind_estimate(b);
        pending_positions.push_back(typed ? typed_want : predicted);
        // sender gap, a burst of idle cycles
        if (idle_on && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
    endtask

    // both step registers, written back to back while the block is idle
    task automatic load_steps(logic [STEP_W-1:0] pct_step, logic [STEP_W-1:0] ang_step);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_PERCENT_STEP;
        cfg_wr_data <= pct_step;
        @(posedge aclk);
        cfg_addr    <= REG_ANGLE_STEP;
        cfg_wr_data <= ang_step;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ticks_per_percent = pct_step;
        ticks_per_degree  = ang_step;
    endtask

    // random content; goals mostly in range, some past the limits
    function automatic in_beat_t fresh_beat(mode_t m);
        in_beat_t b;
        b.mode         = m;
        b.goal_percent = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                     : 7'($urandom_range(0, 100));
        b.goal_angle   = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 180) - 90);
        return b;
    endfunction

    // directed beats, expected report typed in where it is obvious
    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } step_row_t;

    step_row_t directed_rows[$];

    function automatic void add_row(mode_t m, int gp, int ga, bit typed,
                                    dir_t mot, bit o_rly, bit c_rly, int pos, int ang);
        step_row_t r;
        r.beat.mode             = m;
        r.beat.goal_percent     = 7'(gp);
        r.beat.goal_angle       = 8'(ga);
        r.typed                 = typed;
        r.want.motion           = mot;
        r.want.open_relay       = o_rly;
        r.want.close_relay      = c_rly;
        r.want.position_percent = 7'(pos);
        r.want.slat_angle       = 8'(ang);
        directed_rows.push_back(r);
    endfunction

    initial begin : stimulus
        in_beat_t          b;
        mode_t             cmd;
        int                pick;
        int                run;
        int                sent;
        logic [STEP_W-1:0] p_step;
        logic [STEP_W-1:0] a_step;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        error_count  = 0;
        result_index = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        est_reset();

        // reset step values: 300 ticks per percent, so no position moves here
        add_row(MODE_TICK,     0,    0, 1, DIR_STOPPED, 0, 0, 0, 0);  // tick at rest
        add_row(MODE_UNDEF_6, 127,  -1, 1, DIR_STOPPED, 0, 0, 0, 0);  // ignored mode
        add_row(MODE_UNDEF_7,   0, -128, 1, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_PERCENT,   0,    0, 1, DIR_STOPPED, 0, 0, 0, 0);  // goal already met
        add_row(MODE_ANGLE,     0,    0, 1, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_PERCENT, 127,    0, 1, DIR_CLOSING, 0, 1, 0, 0);  // saturates to 100
        add_row(MODE_TICK,      0,    0, 0, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_PERCENT,   0,    0, 1, DIR_CLOSING, 0, 1, 0, 0);  // met, keeps moving
        add_row(MODE_ANGLE,     0,    0, 1, DIR_CLOSING, 0, 1, 0, 0);
        add_row(MODE_OPEN,      0,    0, 1, DIR_OPENING, 1, 0, 0, 0);
        add_row(MODE_TICK,    127,   -1, 0, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_STOP,      0,    0, 1, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_ANGLE,     0, -128, 1, DIR_OPENING, 1, 0, 0, 0);  // clamps to -90
        add_row(MODE_ANGLE,     0,  127, 1, DIR_CLOSING, 0, 1, 0, 0);  // clamps to 90
        add_row(MODE_ANGLE,     0,  -90, 1, DIR_OPENING, 1, 0, 0, 0);
        add_row(MODE_ANGLE,     0,   90, 1, DIR_CLOSING, 0, 1, 0, 0);
        add_row(MODE_PERCENT, 100,    0, 1, DIR_CLOSING, 0, 1, 0, 0);
        add_row(MODE_PERCENT, 101,    0, 1, DIR_CLOSING, 0, 1, 0, 0);
        add_row(MODE_CLOSE,    85,   85, 1, DIR_CLOSING, 0, 1, 0, 0);
        add_row(MODE_STOP,     42,   42, 1, DIR_STOPPED, 0, 0, 0, 0);
        add_row(MODE_TICK,      0,    0, 0, DIR_STOPPED, 0, 0, 0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        settle();

        // random phases, one step setting each, extremes included
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       begin p_step = 16'd1;     a_step = 16'd1;     end
                1:       begin p_step = 16'd0;     a_step = 16'd0;     end
                2:       begin p_step = 16'd1;     a_step = 16'd2;     end
                3:       begin p_step = 16'd3;     a_step = 16'd1;     end
                4:       begin p_step = 16'd65535; a_step = 16'd1;     end
                5:       begin p_step = 16'd1;     a_step = 16'd65535; end
                6:       begin p_step = 16'd2;     a_step = 16'd5;     end
                7:       begin p_step = 16'd65535; a_step = 16'd65535; end
                default: begin p_step = 16'd1;     a_step = 16'd1;     end
            endcase
            // last phase runs flat out on both sides
            if (ph == PHASE_COUNT - 1) idle_on = 1'b0;
            load_steps(p_step, a_step);
            if (ph == 1) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // command followed by a run of ticks
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      cmd = MODE_OPEN;
                    else if (pick == 1) cmd = MODE_CLOSE;
                    else if (pick == 2) cmd = MODE_STOP;
                    else if (pick < 7)  cmd = MODE_PERCENT;
                    else                cmd = MODE_ANGLE;
                    b = fresh_beat(cmd);
                    // now and then ask for where the blind already is
                    if ($urandom_range(0, 7) == 0) begin
                        b.goal_percent = est_pct;
                        b.goal_angle   = est_ang;
                    end
                    send_beat(b, 1'b0, '0);
                    sent++;
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(0, 25);
                    // keep the phase near its beat count
                    if (run > PHASE_BEATS - sent) run = PHASE_BEATS - sent;
                    repeat (run) begin
                        send_beat(fresh_beat(MODE_TICK), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    // noise, undefined modes included
                    b = fresh_beat(mode_t'($urandom_range(0, 7)));
                    send_beat(b, 1'b0, '0);
                    if (b.mode <= MODE_ANGLE) sent++;
                end
            end
            settle();
        end

        // give any straggling results time to arrive
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/vbp_pkg.sv
rtl/venetian_blind_positioner.sv
bench/tb.sv
